FILE: rtl/core/pmr_pkg.sv
// ----------------------------------------------------------------------------
// pmr_pkg: shared types and widths for the poset Moebius row block
// Holds the field widths, the sign class codes and the structs that travel
// between the top level, the cell chain and the cells.
// ----------------------------------------------------------------------------
package pmr_pkg;

    // Width of a node index.
    localparam int NODE_W  = 6;
    // Width of a stored Moebius value.
    localparam int VALUE_W = 32;
    // Running sum width: 64 values of 32 bits never leave 38 signed bits.
    localparam int SUM_W   = 38;

    // Sign class reported with each value.
    typedef enum logic [1:0] {
        CLS_ZERO      = 2'd0,
        CLS_PLUS_ONE  = 2'd1,
        CLS_MINUS_ONE = 2'd2,
        CLS_OTHER     = 2'd3
    } sign_class_t;

    // Partial sum that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
    } pmr_token_t;

    // Store write request: the value of one node goes into its cell.
    typedef struct packed {
        logic                      en;
        logic [NODE_W-1:0]         node;
        logic signed [VALUE_W-1:0] data;
    } pmr_write_t;

endpackage

FILE: rtl/core/pmr_cell.sv
// ----------------------------------------------------------------------------
// pmr_cell: one cell of the Moebius value row
// Holds the value of one node. A passing partial sum picks up that value when
// the node is strictly below the node being worked on, and moves on to the
// next cell in the following cycle.
// ----------------------------------------------------------------------------
module pmr_cell
    import pmr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pmr_token_t                tok_in,
    input  logic                      add_en,
    input  logic                      wr_en,
    input  logic signed [VALUE_W-1:0] wr_data,
    output pmr_token_t                tok_out
);

    logic signed [VALUE_W-1:0] mu_reg;
    logic                      tok_valid_reg;
    logic signed [SUM_W-1:0]   tok_sum_reg;
    logic signed [SUM_W-1:0]   addend;
    logic signed [SUM_W-1:0]   tok_sum_next;

    // Sign-extend the stored value when this node counts toward the sum.
    always_comb begin
        if (add_en) begin
            addend = {{(SUM_W - VALUE_W){mu_reg[VALUE_W-1]}}, mu_reg};
        end else begin
            addend = '0;
        end
        tok_sum_next = tok_in.sum + addend;
    end

    // Token handoff; only the valid bit is control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    // Payload: running sum and the stored node value.
    always_ff @(posedge aclk) begin
        tok_sum_reg <= tok_sum_next;
        if (wr_en) begin
            mu_reg <= wr_data;
        end
    end

    assign tok_out.valid = tok_valid_reg;
    assign tok_out.sum   = tok_sum_reg;

endmodule

FILE: rtl/core/pmr_chain.sv
// ----------------------------------------------------------------------------
// pmr_chain: row of value cells
// One cell per node. The partial sum enters at cell 0 and leaves after the
// last cell; store writes are decoded to the cell of the written node.
// ----------------------------------------------------------------------------
module pmr_chain
    import pmr_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pmr_token_t           tok_in,
    input  logic [MAX_NODES-1:0] lower_mask,
    input  pmr_write_t           wr,
    output pmr_token_t           tok_out
);

    pmr_token_t tok [0:MAX_NODES];

    assign tok[0]  = tok_in;
    assign tok_out = tok[MAX_NODES];

    // Each cell adds its value when its node is strictly below the current one.
    for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
        logic cell_wr_en;

        assign cell_wr_en = wr.en && (wr.node == NODE_W'(i));

        pmr_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[i]),
            .add_en  (lower_mask[i]),
            .wr_en   (cell_wr_en),
            .wr_data (wr.data),
            .tok_out (tok[i+1])
        );
    end

endmodule

FILE: rtl/core/poset_mobius_row.sv
// ----------------------------------------------------------------------------
// poset_mobius_row: Moebius row mu(anchor, v) of a partial order
// Streams nodes in linear extension order and returns one Moebius value each.
// ----------------------------------------------------------------------------
// Each node is a transfer carrying its index and the mask of nodes below or
// equal to it; the anchor node is set through the configuration channel, and
// the user must set it only while the block is idle: the block itself does not
// enforce this. The anchor itself yields 1 and a node not above the anchor
// yields 0; such an item moves to the done state on acceptance and its result
// is then loaded into the output register. Any other node walks a partial sum
// down a row of MAX_NODES cells, one cell per cycle, each cell holding the
// value of one node; its result then passes the done state into the output
// register. In either case the next input transfer is taken in the cycle after
// the result is loaded into the output register, so the block takes no new
// node before it is through with the last one. A result that waits in the
// output register holds off the next one, and with it the next input transfer.
// The sum is negated and saturated to 32 bits, with the overflowed flag set
// when clipping occurred. Values of nodes never presented since reset are
// unknown, so every node must come after all nodes below it. No clearing pass is run after reset.
// ----------------------------------------------------------------------------
module poset_mobius_row
    import pmr_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: anchor node index.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,

    // Input nodes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // node_index[5:0], below_mask[69:6], zero pad
    input  logic        s_tlast,   // last_node

    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_node[5:0], mobius_value[37:6],
                                   // sign_class[39:38], overflowed[40], zero pad
    output logic        m_tlast    // last_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    logic [NODE_W-1:0]         anchor_reg;
    logic [NODE_W-1:0]         node_reg;
    logic [MAX_NODES-1:0]      lower_mask_reg;
    logic                      last_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic                      start_reg;

    logic                      m_tvalid_reg;
    logic [NODE_W-1:0]         m_node_reg;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic [1:0]                m_cls_reg;
    logic                      m_ovf_reg;
    logic                      m_last_reg;

    logic [NODE_W-1:0]         in_node;
    logic [63:0]               in_mask;
    logic                      in_accept;
    logic                      anchor_hit;
    logic                      is_anchor;
    logic [MAX_NODES-1:0]      self_bit;
    logic                      out_free;

    logic signed [SUM_W:0]     neg_sum;
    logic signed [VALUE_W-1:0] sat_value;
    logic                      sat_ovf;
    logic [1:0]                sat_cls;

    pmr_token_t                chain_in;
    pmr_token_t                chain_out;
    pmr_write_t                store_wr;

    // Input unpacking and the checks that settle the trivial cases.
    assign in_node    = s_tdata[5:0];
    assign in_mask    = s_tdata[69:6];
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign is_anchor  = (in_node == anchor_reg);
    assign anchor_hit = ({1'b0, anchor_reg} < (NODE_W + 1)'(MAX_NODES)) &&
                        in_mask[anchor_reg];
    assign self_bit   = MAX_NODES'(1) << in_node;
    assign out_free   = !m_tvalid_reg || m_tready;

    // Negate the collected sum and clip it to 32 bits.
    always_comb begin
        neg_sum = -{sum_reg[SUM_W-1], sum_reg};
        if (neg_sum[SUM_W:VALUE_W-1] == '0 || neg_sum[SUM_W:VALUE_W-1] == '1) begin
            sat_value = neg_sum[VALUE_W-1:0];
            sat_ovf   = 1'b0;
        end else if (neg_sum[SUM_W]) begin
            sat_value = {1'b1, {(VALUE_W - 1){1'b0}}};
            sat_ovf   = 1'b1;
        end else begin
            sat_value = {1'b0, {(VALUE_W - 1){1'b1}}};
            sat_ovf   = 1'b1;
        end

        if (sat_value == '0) begin
            sat_cls = CLS_ZERO;
        end else if (sat_value == VALUE_W'(1)) begin
            sat_cls = CLS_PLUS_ONE;
        end else if (sat_value == '1) begin
            sat_cls = CLS_MINUS_ONE;
        end else begin
            sat_cls = CLS_OTHER;
        end
    end

    // Chain feed and the store write that completes each item.
    assign chain_in.valid = start_reg;
    assign chain_in.sum   = '0;
    assign store_wr.en    = (state_reg == ST_DONE) && out_free;
    assign store_wr.node  = node_reg;
    assign store_wr.data  = sat_value;

    pmr_chain #(
        .MAX_NODES (MAX_NODES)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tok_in     (chain_in),
        .lower_mask (lower_mask_reg),
        .wr         (store_wr),
        .tok_out    (chain_out)
    );

    // Control: sequencer, anchor register and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            anchor_reg   <= '0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                anchor_reg <= cfg_data;
            end
            // A partial sum is launched only for nodes above a foreign anchor.
            start_reg <= in_accept && !is_anchor && anchor_hit;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (!is_anchor && anchor_hit) begin
                            state_reg <= ST_SUM;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SUM: begin
                    if (chain_out.valid) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers of the item in work and of the output stage.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            node_reg       <= in_node;
            last_reg       <= s_tlast;
            lower_mask_reg <= in_mask[MAX_NODES-1:0] & ~self_bit;
            // The anchor is the negation of a sum of minus one; others start at zero.
            if (is_anchor) begin
                sum_reg <= '1;
            end else begin
                sum_reg <= '0;
            end
        end else if (state_reg == ST_SUM && chain_out.valid) begin
            sum_reg <= chain_out.sum;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_node_reg  <= node_reg;
            m_value_reg <= sat_value;
            m_cls_reg   <= sat_cls;
            m_ovf_reg   <= sat_ovf;
            m_last_reg  <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_ovf_reg, m_cls_reg, m_value_reg, m_node_reg};
    assign m_tlast  = m_last_reg;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the poset Moebius row block
// Feeds node transfers in linear extension order: hand-picked corner cases,
// random partial orders, random single nodes and runs that drive the sums into
// saturation. Every result transfer is checked field by field against a
// Moebius predictor kept inside the bench. The run covers several anchor
// settings and three pacing modes on both streams.
// ----------------------------------------------------------------------------
module testbench
    import pmr_pkg::*;
();

    // Cycle budget for the whole run.
    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     PHASES       = 6;
    localparam int     PHASE_ITEMS  = 200;
    localparam int     GROW_ITEMS   = 60;
    localparam longint MOBIUS_MAX   = 64'sd2147483647;
    localparam longint MOBIUS_MIN   = -64'sd2147483648;

    typedef struct {
        logic [NODE_W-1:0] node;
        logic [63:0]       mask;
        logic              last;
    } node_item_t;

    typedef struct {
        logic [NODE_W-1:0]         node;
        logic signed [VALUE_W-1:0] value;
        sign_class_t               cls;
        logic                      ovf;
        logic                      last;
    } mobius_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    // Predictor state: anchor register and one Moebius value per node.
    logic [NODE_W-1:0] anchor_sel = '0;
    int                mu_mem [64];

    node_item_t        node_q [$];
    mobius_result_t    mu_expect_q [$];
    logic [63:0]       seen_nodes = '0;
    logic [NODE_W-1:0] grow_next  = '0;
    int                idle_mode  = 0;
    int                issued     = 0;
    int                checked    = 0;
    int                fail_count = 0;
    int                saturated  = 0;
    int                anchor_settings = 0;
    int                cls_count [4] = '{0, 0, 0, 0};
    int                cycle_count = 0;
    bit                s_fire = 1'b0;

    poset_mobius_row i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Moebius value of one node: updates the stored row and returns the result.
    function automatic mobius_result_t mobius_step(logic [NODE_W-1:0] node,
                                                   logic [63:0] mask, logic last);
        mobius_result_t r;
        longint         acc;
        longint         val;
        r.node = node;
        r.ovf  = 1'b0;
        r.last = last;
        if (node == anchor_sel) begin
            val = 1;
        end else if (!mask[anchor_sel]) begin
            val = 0;
        end else begin
            acc = 0;
            for (int z = 0; z < 64; z++) begin
                if (mask[z] && z != node) acc += mu_mem[z];
            end
            val = -acc;
            if (val > MOBIUS_MAX) begin
                val   = MOBIUS_MAX;
                r.ovf = 1'b1;
            end else if (val < MOBIUS_MIN) begin
                val   = MOBIUS_MIN;
                r.ovf = 1'b1;
            end
        end
        mu_mem[node] = int'(val);
        r.value = val[31:0];
        if (val == 0) r.cls = CLS_ZERO;
        else if (val == 1) r.cls = CLS_PLUS_ONE;
        else if (val == -1) r.cls = CLS_MINUS_ONE;
        else r.cls = CLS_OTHER;
        cls_count[r.cls]++;
        if (r.ovf) saturated++;
        return r;
    endfunction

    // Input side: the prediction is made at the edge where the transfer happens.
    always @(posedge aclk) begin
        mobius_result_t pred;
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) begin
            pred = mobius_step(s_tdata[5:0], s_tdata[69:6], s_tlast);
            mu_expect_q = {mu_expect_q, pred};
        end
    end

    // Input driver: loads the next pending node unless the sender idles.
    always @(negedge aclk) begin
        node_item_t nxt;
        int         pct;
        pct = (idle_mode == 0) ? 31 : (idle_mode == 1) ? 63 : 0;
        if (!s_tvalid || s_fire) begin
            if (node_q.size() != 0 && $urandom_range(99) >= pct) begin
                nxt = node_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, nxt.mask, nxt.node};
                s_tlast  <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        int pct;
        pct = (idle_mode == 0) ? 63 : (idle_mode == 1) ? 31 : 0;
        m_tready <= ($urandom_range(99) >= pct);
    end

    // Result checker: each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        mobius_result_t want;
        logic signed [VALUE_W-1:0] got_value;
        if (aresetn && m_tvalid && m_tready) begin
            got_value = m_tdata[37:6];
            if (mu_expect_q.size() == 0) begin
                $error("result transfer for node %0d with no expectation", m_tdata[5:0]);
                fail_count++;
            end else begin
                want = mu_expect_q.pop_front();
                checked++;
                if (m_tdata[5:0] != want.node) begin
                    $error("result_node: expected %0d, got %0d", want.node, m_tdata[5:0]);
                    fail_count++;
                end
                if (got_value != want.value) begin
                    $error("mobius_value: expected %0d, got %0d", want.value, got_value);
                    fail_count++;
                end
                if (m_tdata[39:38] != want.cls) begin
                    $error("sign_class: expected %0d, got %0d", want.cls, m_tdata[39:38]);
                    fail_count++;
                end
                if (m_tdata[40] != want.ovf) begin
                    $error("overflowed: expected %0d, got %0d", want.ovf, m_tdata[40]);
                    fail_count++;
                end
                if (m_tlast != want.last) begin
                    $error("last_result: expected %0d, got %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due.",
                     cycle_count, mu_expect_q.size());
            $display("poset_mobius_row test failed");
            $finish;
        end
    end

    // Queues one node. Mask bits of nodes not yet presented since reset are
    // dropped so that no stored value is read before it was written.
    task automatic queue_node(logic [NODE_W-1:0] node, logic [63:0] mask, logic last);
        node_item_t it;
        it.node = node;
        it.mask = mask & (seen_nodes | (64'd1 << node));
        it.last = last;
        node_q = {node_q, it};
        seen_nodes[node] = 1'b1;
        issued++;
    endtask

    // Waits until every queued node is accepted, and optionally every result in.
    task automatic wait_idle(bit results_too);
        @(posedge aclk);
        while (node_q.size() != 0 || s_tvalid || (results_too && mu_expect_q.size() != 0))
            @(posedge aclk);
    endtask

    task automatic set_anchor(logic [5:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        anchor_sel = value;
        anchor_settings++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One random partial order of k nodes, presented in linear extension order.
    // Each mask is the down-closure of randomly chosen earlier nodes.
    task automatic poset_run(int k, bit with_anchor);
        int          pool [64];
        logic [63:0] closure [64];
        logic [63:0] sent;
        int          j;
        int          tmp;
        int          density;
        for (int i = 0; i < 64; i++) pool[i] = i;
        for (int i = 63; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        if (with_anchor) begin
            for (int i = k; i < 64; i++) begin
                if (pool[i] == anchor_sel) begin
                    j = $urandom_range(k - 1);
                    pool[i] = pool[j];
                    pool[j] = int'(anchor_sel);
                end
            end
        end
        density = $urandom_range(10, 60);
        for (int i = 0; i < k; i++) begin
            closure[i] = 64'd1 << pool[i];
            for (int p = 0; p < i; p++) begin
                if ($urandom_range(99) < density) closure[i] |= closure[p];
            end
            sent = closure[i];
            // The node's own bit carries no weight; drop it now and then.
            if ($urandom_range(3) == 0) sent[pool[i]] = 1'b0;
            queue_node(NODE_W'(pool[i]), sent, i == k - 1);
        end
    endtask

    // Chain of nodes whose sums keep growing until they saturate: each node
    // sums the side (positive or negative) with the larger stored magnitude.
    task automatic grow_run(int n);
        longint            pos_sum;
        longint            neg_sum;
        logic [63:0]       pos_set;
        logic [63:0]       neg_set;
        logic [NODE_W-1:0] tgt;
        if (!seen_nodes[anchor_sel]) queue_node(anchor_sel, 64'd0, 1'b0);
        for (int i = 0; i < n; i++) begin
            wait_idle(1'b0);
            tgt = grow_next;
            if (tgt == anchor_sel) tgt = tgt + 1'b1;
            grow_next = tgt + 1'b1;
            pos_sum = (mu_mem[anchor_sel] > 0) ? mu_mem[anchor_sel] : 0;
            neg_sum = (mu_mem[anchor_sel] < 0) ? mu_mem[anchor_sel] : 0;
            pos_set = '0;
            neg_set = '0;
            for (int z = 0; z < 64; z++) begin
                if (seen_nodes[z] && z != anchor_sel && z != tgt) begin
                    if (mu_mem[z] > 0) begin
                        pos_sum += mu_mem[z];
                        pos_set[z] = 1'b1;
                    end else if (mu_mem[z] < 0) begin
                        neg_sum += mu_mem[z];
                        neg_set[z] = 1'b1;
                    end
                end
            end
            queue_node(tgt, ((pos_sum >= -neg_sum) ? pos_set : neg_set) |
                            (64'd1 << anchor_sel) | (64'd1 << tgt), i == n - 1);
        end
    endtask

    // Single node with random content, dense or sparse mask.
    task automatic noise_node();
        logic [63:0] mask;
        mask = {$urandom, $urandom};
        if ($urandom_range(1) == 0) mask &= {$urandom, $urandom};
        if ($urandom_range(1) == 0) mask[anchor_sel] = 1'b1;
        queue_node(NODE_W'($urandom_range(63)), mask, $urandom_range(7) == 0);
    endtask

    // Corner cases after reset, anchor at node 0.
    task automatic corner_nodes();
        queue_node(6'd0,  64'h0,   1'b0);   // anchor without its own bit
        queue_node(6'd1,  64'h3,   1'b0);   // minus one
        queue_node(6'd2,  64'h7,   1'b0);   // sum cancels to zero
        queue_node(6'd3,  64'h9,   1'b0);
        queue_node(6'd4,  64'h1b,  1'b0);   // plus one away from the anchor
        queue_node(6'd5,  64'hb,   1'b0);
        queue_node(6'd6,  64'h71,  1'b0);   // larger magnitude
        queue_node(6'd7,  64'h41,  1'b0);
        queue_node(6'd8,  64'h6,   1'b0);   // not above the anchor
        queue_node(6'd9,  64'h0,   1'b0);   // empty mask
        queue_node(6'd0,  64'h3ff, 1'b0);   // anchor presented again
        queue_node(6'd2,  64'h81,  1'b0);   // repeated node overwrites its value
        queue_node(6'd10, 64'h5,   1'b0);
        queue_node(6'd63, 64'h8000_0000_0000_0001, 1'b0);
        queue_node(6'd62, 64'h8000_0000_0000_0001, 1'b1);  // higher node read out of order
    endtask

    // Stimulus sequencer.
    initial begin
        int  target;
        bit  paused;
        int  k;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle(1'b1);
            idle_mode = ph / 2;
            case (ph)
                0: set_anchor(6'd0);
                1, 5: set_anchor(6'd63);
                default: set_anchor(6'($urandom_range(63)));
            endcase
            if (ph == 0) begin
                corner_nodes();
            end else begin
                queue_node(anchor_sel, '1, 1'b0);
                queue_node(NODE_W'($urandom_range(63)), '1, 1'b0);
                queue_node(NODE_W'($urandom_range(63)), '0, 1'b1);
            end
            grow_run(GROW_ITEMS);
            target = issued + PHASE_ITEMS - GROW_ITEMS;
            paused = 1'b0;
            while (issued < target) begin
                if ($urandom_range(99) < 75) begin
                    k = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
                    poset_run(k, $urandom_range(4) != 0);
                end else begin
                    repeat ($urandom_range(1, 4)) noise_node();
                end
                // Halfway through, hold the sender until all results are back.
                if (!paused && issued >= target - PHASE_ITEMS / 2) begin
                    wait_idle(1'b1);
                    paused = 1'b1;
                end
            end
        end

        wait_idle(1'b1);
        repeat (80) @(posedge aclk);
        if (mu_expect_q.size() != 0) begin
            $error("%0d expected results never arrived", mu_expect_q.size());
            fail_count++;
        end
        $display("Run covered %0d node transfers and %0d result checks over %0d anchor settings.",
                 issued, checked, anchor_settings);
        $display("Values by class zero/+1/-1/other: %0d/%0d/%0d/%0d, saturated sums: %0d.",
                 cls_count[CLS_ZERO], cls_count[CLS_PLUS_ONE], cls_count[CLS_MINUS_ONE],
                 cls_count[CLS_OTHER], saturated);
        if (fail_count == 0) begin
            $display("poset_mobius_row test passed");
        end else begin
            $display("poset_mobius_row test failed");
        end
        $finish;
    end

endmodule
